// ===== src/imhq_pkg.sv =====
// Shared types and constants for the indexed min-heap queue.
`default_nettype none
package imhq_pkg;
    localparam int ID_W     = 8;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 8;
    localparam int CNT_W    = 9;
    localparam int CAPACITY = 256;

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_EXTRACT = 2'd1;
    localparam logic [1:0] MODE_UPDATE  = 2'd2;
    localparam logic [1:0] MODE_LOOKUP  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    // one heap slot: id and a copy of its key
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_slot;

    // per-id record: key and heap position
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
    } t_id_rec;
endpackage
`default_nettype wire

// ===== src/imhq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module imhq_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/indexed_min_heap_queue_top.sv =====
// Indexed binary min-heap (decrease-key) with id-indexed key and position store.
// Lookup reads the id RAM; insert and update climb level by level toward the root; extract
// moves the last entry to the root and descends level by level. The input reopens in the
// same cycle that the result becomes valid.
// One item at a time; each level needs one or two heap RAM reads then a write-back.
// Result is held in an output register, so the next item can enter while it waits.
// Synchronous active-low reset clears state, count, presence bits and output valid.
`default_nettype none
module indexed_min_heap_queue_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_mode,
    input  wire logic [imhq_pkg::ID_W-1:0]   i_node_id,
    input  wire logic [imhq_pkg::KEY_W-1:0]  i_key_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [imhq_pkg::ID_W-1:0]        o_result_id,
    output logic [imhq_pkg::KEY_W-1:0]       o_result_key,
    output logic [imhq_pkg::CNT_W-1:0]       o_entry_count,
    output logic [1:0]                       o_status
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOOK   = 4'd1;
    localparam logic [3:0] S_UPD    = 4'd2;
    localparam logic [3:0] S_XR0    = 4'd3;
    localparam logic [3:0] S_XR1    = 4'd4;
    localparam logic [3:0] S_SU_RD  = 4'd5;
    localparam logic [3:0] S_SU_CMP = 4'd6;
    localparam logic [3:0] S_SD_RD  = 4'd7;
    localparam logic [3:0] S_SD_L   = 4'd8;
    localparam logic [3:0] S_SD_R   = 4'd9;
    localparam logic [3:0] S_PLACE  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0] r_state, n_state;
    logic [imhq_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [imhq_pkg::CAPACITY-1:0] r_present, n_present;
    imhq_pkg::t_slot r_item, n_item;
    imhq_pkg::t_slot r_lchild, n_lchild;
    logic [imhq_pkg::POS_W-1:0] r_pos, n_pos;
    logic [imhq_pkg::ID_W-1:0] r_res_id, n_res_id;
    logic [imhq_pkg::KEY_W-1:0] r_res_key, n_res_key;
    logic [1:0] r_status, n_status;

    logic [imhq_pkg::ID_W-1:0]  r_o_id;
    logic [imhq_pkg::KEY_W-1:0] r_o_key;
    logic [imhq_pkg::CNT_W-1:0] r_o_cnt;
    logic [1:0]                 r_o_status;
    logic                       r_o_valid;

    // heap RAM port signals
    logic h_we;
    logic [imhq_pkg::POS_W-1:0] h_wa, h_ra;
    imhq_pkg::t_slot h_wd, h_rd;
    // id RAM port signals
    logic d_we;
    logic [imhq_pkg::ID_W-1:0] d_wa, d_ra;
    imhq_pkg::t_id_rec d_wd, d_rd;

    logic accept;
    logic [imhq_pkg::POS_W-1:0] parent;
    logic [imhq_pkg::CNT_W-1:0] child, child_r, cnt_m1;
    logic out_free;
    imhq_pkg::t_slot cand;
    logic [imhq_pkg::POS_W-1:0] cand_idx;

    imhq_ram #(.ADDR_W(imhq_pkg::POS_W), .DATA_W($bits(imhq_pkg::t_slot))) u_heap_ram (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd)
    );

    imhq_ram #(.ADDR_W(imhq_pkg::ID_W), .DATA_W($bits(imhq_pkg::t_id_rec))) u_id_ram (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_wa), .i_wdata(d_wd),
        .i_raddr(d_ra), .o_rdata(d_rd)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_o_valid || !i_out_stall;
    assign parent     = (r_pos - 1'b1) >> 1;
    assign child      = {r_pos, 1'b1};
    assign child_r    = child + 1'b1;
    assign cnt_m1     = r_cnt - 1'b1;

    // child chosen for the downward step; left wins ties
    always_comb begin
        if (r_state == S_SD_R && r_lchild.key > h_rd.key) begin
            cand     = h_rd;
            cand_idx = child_r[imhq_pkg::POS_W-1:0];
        end else if (r_state == S_SD_R) begin
            cand     = r_lchild;
            cand_idx = child[imhq_pkg::POS_W-1:0];
        end else begin
            cand     = h_rd;
            cand_idx = child[imhq_pkg::POS_W-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_present = r_present;
        n_item    = r_item;
        n_lchild  = r_lchild;
        n_pos     = r_pos;
        n_res_id  = r_res_id;
        n_res_key = r_res_key;
        n_status  = r_status;
        h_we = 1'b0;
        h_wa = r_pos;
        h_wd = r_item;
        h_ra = '0;
        d_we = 1'b0;
        d_wa = r_item.id;
        d_wd = '{key: r_item.key, pos: r_pos};
        d_ra = i_node_id;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_id  = i_node_id;
                    n_res_key = '0;
                    n_status  = imhq_pkg::ST_OK;
                    n_item    = '{id: i_node_id, key: i_key_value};
                    unique case (i_mode)
                        imhq_pkg::MODE_INSERT: begin
                            if (r_present[i_node_id] ||
                                r_cnt == imhq_pkg::CNT_W'(imhq_pkg::CAPACITY)) begin
                                n_status = imhq_pkg::ST_FULL;
                                n_state  = S_OUT;
                            end else begin
                                n_pos                = r_cnt[imhq_pkg::POS_W-1:0];
                                n_cnt                = r_cnt + 1'b1;
                                n_present[i_node_id] = 1'b1;
                                n_res_key            = i_key_value;
                                n_state              = S_SU_RD;
                            end
                        end
                        imhq_pkg::MODE_EXTRACT: begin
                            if (r_cnt == '0) begin
                                n_status = imhq_pkg::ST_EMPTY;
                                n_res_id = '0;
                                n_state  = S_OUT;
                            end else begin
                                h_ra    = '0;
                                n_state = S_XR0;
                            end
                        end
                        imhq_pkg::MODE_UPDATE: begin
                            if (!r_present[i_node_id]) begin
                                n_status = imhq_pkg::ST_ABSENT;
                                n_state  = S_OUT;
                            end else begin
                                n_res_key = i_key_value;
                                n_state   = S_UPD;
                            end
                        end
                        imhq_pkg::MODE_LOOKUP: begin
                            if (!r_present[i_node_id]) begin
                                n_status = imhq_pkg::ST_ABSENT;
                                n_state  = S_OUT;
                            end else begin
                                n_state = S_LOOK;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_LOOK: begin
                n_res_key = d_rd.key;
                n_state   = S_OUT;
            end
            S_UPD: begin
                n_pos   = d_rd.pos;
                n_state = S_SU_RD;
            end
            S_XR0: begin
                n_res_id             = h_rd.id;
                n_res_key            = h_rd.key;
                n_present[h_rd.id]   = 1'b0;
                n_cnt                = cnt_m1;
                h_ra                 = cnt_m1[imhq_pkg::POS_W-1:0];
                n_state              = (cnt_m1 == '0) ? S_OUT : S_XR1;
            end
            S_XR1: begin
                n_item  = h_rd;
                n_pos   = '0;
                n_state = S_SD_RD;
            end
            S_SU_RD: begin
                if (r_pos == '0) begin
                    n_state = S_PLACE;
                end else begin
                    h_ra    = parent;
                    n_state = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                // parent moves down into the hole
                if (h_rd.key > r_item.key) begin
                    h_we    = 1'b1;
                    h_wd    = h_rd;
                    d_we    = 1'b1;
                    d_wa    = h_rd.id;
                    d_wd    = '{key: h_rd.key, pos: r_pos};
                    n_pos   = parent;
                    n_state = S_SU_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_SD_RD: begin
                if (child >= r_cnt) begin
                    n_state = S_PLACE;
                end else begin
                    h_ra    = child[imhq_pkg::POS_W-1:0];
                    n_state = S_SD_L;
                end
            end
            S_SD_L, S_SD_R: begin
                if (r_state == S_SD_L && child_r < r_cnt) begin
                    n_lchild = h_rd;
                    h_ra     = child_r[imhq_pkg::POS_W-1:0];
                    n_state  = S_SD_R;
                end else if (r_item.key > cand.key) begin
                    // smaller child moves up into the hole
                    h_we    = 1'b1;
                    h_wd    = cand;
                    d_we    = 1'b1;
                    d_wa    = cand.id;
                    d_wd    = '{key: cand.key, pos: r_pos};
                    n_pos   = cand_idx;
                    n_state = S_SD_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                h_we    = 1'b1;
                d_we    = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_present <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_present <= n_present;
            if (r_state == S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_lchild  <= n_lchild;
        r_pos     <= n_pos;
        r_res_id  <= n_res_id;
        r_res_key <= n_res_key;
        r_status  <= n_status;
        if (r_state == S_OUT && out_free) begin
            r_o_id     <= r_res_id;
            r_o_key    <= r_res_key;
            r_o_cnt    <= r_cnt;
            r_o_status <= r_status;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_result_id   = r_o_id;
    assign o_result_key  = r_o_key;
    assign o_entry_count = r_o_cnt;
    assign o_status      = r_o_status;
endmodule
`default_nettype wire

// ===== src/imhq_chk.sv =====
// Port-level checker for the indexed min-heap queue, bound to the top level.
`default_nettype none
module imhq_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_result_id,
    input wire logic [31:0] o_result_key,
    input wire logic [8:0]  o_entry_count,
    input wire logic [1:0]  o_status
);
    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_key)
            && $stable(o_status))
        else $error("stalled result changed");

    // one item in flight: accepted beat closes the input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after accept");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == imhq_pkg::ST_EMPTY |->
            o_result_id == 8'd0 && o_result_key == 32'd0 && o_entry_count == 9'd0)
        else $error("bad empty result");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == imhq_pkg::ST_FULL || o_status == imhq_pkg::ST_ABSENT)
            |-> o_result_key == 32'd0)
        else $error("rejected op returned a key");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= 9'd256)
        else $error("count beyond capacity");
endmodule

bind indexed_min_heap_queue_top imhq_chk u_imhq_chk (.*);
`default_nettype wire
